// File: rtl/cvmb_pkg.sv
// Shared widths, item types and pipeline carry types for the camera view matrix builder.
// No dependencies; every module of the block imports this package.
`default_nettype none

package cvmb_pkg;

  localparam int unsigned WORD_W  = 32;            // Q16.16 port word
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned AXES    = 3;
  localparam int unsigned VEC_W   = 64;            // normalizer input component
  localparam int unsigned UNIT_W  = 18;            // signed unit component, |v| <= 1.0
  localparam int unsigned MAG_W   = 31;            // scaled magnitude, msb at bit 30
  localparam int unsigned SH_W    = 6;             // bit position in a VEC_W word
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GRP_N   = VEC_W / BYTE_W;
  localparam int unsigned GRP_W   = 3;
  localparam int unsigned BIT_W   = 3;
  localparam int unsigned ROOT_W  = VEC_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 4;
  localparam int unsigned NSH_W   = FRAC_W + 1;    // numerator scale and quotient bits
  localparam int unsigned DEN_W   = ROOT_W + 1;
  localparam int unsigned NUM_W   = MAG_W + NSH_W + 1;
  localparam int unsigned DREM_W  = DEN_W + 1;
  localparam int unsigned XP_W    = UNIT_W + WORD_W;
  localparam int unsigned YP_W    = 2 * UNIT_W;
  localparam int unsigned RW_W    = YP_W + 1;
  localparam int unsigned RN_W    = 20;
  localparam int unsigned DP_W    = 54;
  localparam int unsigned PTR_W   = 2;
  localparam int unsigned FIFO_DEPTH = 1 << PTR_W;
  localparam int unsigned CNT_W   = PTR_W + 1;

  localparam logic [SH_W-1:0] MSB_TGT = SH_W'(MAG_W - 1);

  typedef logic [AXES-1:0][WORD_W-1:0] vec3_t;
  typedef logic [AXES-1:0][VEC_W-1:0]  wide3_t;
  typedef logic [AXES-1:0][UNIT_W-1:0] unit3_t;
  typedef logic [AXES-1:0][MAG_W-1:0]  mag3_t;

  typedef struct packed {
    vec3_t right;
    vec3_t fwd;
    vec3_t pos;
  } in_item_t;

  typedef struct packed {
    vec3_t right;
    vec3_t up;
    vec3_t fwd;
    vec3_t trans;   // right, up, forward translations
  } res_item_t;

  typedef struct packed {
    vec3_t a;
    vec3_t pos;
  } side_t;

  typedef struct packed {
    logic            vld;
    logic            zero;
    logic [AXES-1:0] neg;
    mag3_t           mag;
    side_t           side;
  } nrm_ctl_t;

endpackage

`default_nettype wire

// File: rtl/cvmb_front.sv
// Input queue of the camera view matrix builder: takes items from the push side.
// Depends on cvmb_pkg.
`default_nettype none

module cvmb_front
  import cvmb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     vld_o,
  output in_item_t item_o
);

  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  in_item_t         mem_q [FIFO_DEPTH];
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

// File: rtl/cvmb_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, bit-serial square root stages,
// restoring divide stages. Result in signed Q2.16 unit form. Depends on cvmb_pkg.
`default_nettype none

module cvmb_norm
  import cvmb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   vld_i,
  input  wide3_t vec_i,
  input  side_t  side_i,
  output logic   vld_o,
  output unit3_t unit_o,
  output side_t  side_o
);

  // stage A: sign and magnitude
  logic            a_vld_q;
  logic [AXES-1:0] a_neg_q, a_neg_d;
  wide3_t          a_mag_q, a_mag_d;
  side_t           a_side_q;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      a_neg_d[i] = vec_i[i][VEC_W-1];
      a_mag_d[i] = a_neg_d[i] ? (VEC_W'(0) - vec_i[i]) : vec_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      a_neg_q  <= '0;
      a_mag_q  <= '0;
      a_side_q <= '0;
    end else if (en_i) begin
      a_vld_q  <= vld_i;
      a_neg_q  <= a_neg_d;
      a_mag_q  <= a_mag_d;
      a_side_q <= side_i;
    end
  end

  // stage B: highest nonzero byte of the OR of magnitudes
  logic             b_vld_q, b_zero_q, b_zero_d;
  logic [AXES-1:0]  b_neg_q;
  wide3_t           b_mag_q;
  side_t            b_side_q;
  logic [GRP_W-1:0] b_grp_q, b_grp_d;
  logic [BYTE_W-1:0] b_byte_q, b_byte_d;
  logic [VEC_W-1:0] orv;

  always_comb begin
    orv     = a_mag_q[0] | a_mag_q[1] | a_mag_q[2];
    b_grp_d = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (orv[g*BYTE_W +: BYTE_W] != '0) b_grp_d = GRP_W'(g);
    end
    b_byte_d = orv[{b_grp_d, 3'b000} +: BYTE_W];
    b_zero_d = (orv == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      b_zero_q <= 1'b0;
      b_neg_q  <= '0;
      b_mag_q  <= '0;
      b_side_q <= '0;
      b_grp_q  <= '0;
      b_byte_q <= '0;
    end else if (en_i) begin
      b_vld_q  <= a_vld_q;
      b_zero_q <= b_zero_d;
      b_neg_q  <= a_neg_q;
      b_mag_q  <= a_mag_q;
      b_side_q <= a_side_q;
      b_grp_q  <= b_grp_d;
      b_byte_q <= b_byte_d;
    end
  end

  // stage C: leading one position
  logic            c_vld_q, c_zero_q;
  logic [AXES-1:0] c_neg_q;
  wide3_t          c_mag_q;
  side_t           c_side_q;
  logic [SH_W-1:0] c_msb_q;
  logic [BIT_W-1:0] bit_d;

  always_comb begin
    bit_d = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      if (b_byte_q[b]) bit_d = BIT_W'(b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q  <= 1'b0;
      c_zero_q <= 1'b0;
      c_neg_q  <= '0;
      c_mag_q  <= '0;
      c_side_q <= '0;
      c_msb_q  <= '0;
    end else if (en_i) begin
      c_vld_q  <= b_vld_q;
      c_zero_q <= b_zero_q;
      c_neg_q  <= b_neg_q;
      c_mag_q  <= b_mag_q;
      c_side_q <= b_side_q;
      c_msb_q  <= {b_grp_q, bit_d};
    end
  end

  // stage D: shift so the largest magnitude has its msb at bit 30 (right shift truncates)
  nrm_ctl_t         d_ctl_q;
  mag3_t            d_mag_d;
  logic [VEC_W-1:0] sh;

  always_comb begin
    sh = '0;
    for (int i = 0; i < AXES; i++) begin
      if (c_msb_q >= MSB_TGT) sh = c_mag_q[i] >> (c_msb_q - MSB_TGT);
      else                    sh = c_mag_q[i] << (MSB_TGT - c_msb_q);
      d_mag_d[i] = sh[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_ctl_q <= '0;
    end else if (en_i) begin
      d_ctl_q.vld  <= c_vld_q;
      d_ctl_q.zero <= c_zero_q;
      d_ctl_q.neg  <= c_neg_q;
      d_ctl_q.mag  <= d_mag_d;
      d_ctl_q.side <= c_side_q;
    end
  end

  // stage E: squares
  nrm_ctl_t                         e_ctl_q;
  logic [AXES-1:0][2*MAG_W-1:0]     e_sq_q, e_sq_d;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      e_sq_d[i] = d_ctl_q.mag[i] * d_ctl_q.mag[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_ctl_q <= '0;
      e_sq_q  <= '0;
    end else if (en_i) begin
      e_ctl_q <= d_ctl_q;
      e_sq_q  <= e_sq_d;
    end
  end

  // square root stages, one root bit each
  nrm_ctl_t          sq_ctl_q  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root_q [0:ROOT_W];
  logic [VEC_W-1:0]  sq_s_q    [0:ROOT_W-1];
  logic [REM_W-1:0]  sq_rem_q  [0:ROOT_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_ctl_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_s_q[0]    <= '0;
      sq_rem_q[0]  <= '0;
    end else if (en_i) begin
      sq_ctl_q[0]  <= e_ctl_q;
      sq_root_q[0] <= '0;
      sq_s_q[0]    <= VEC_W'(e_sq_q[0]) + VEC_W'(e_sq_q[1]) + VEC_W'(e_sq_q[2]);
      sq_rem_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh, trial;
    logic             ge;

    always_comb begin
      rem_sh = {sq_rem_q[k][REM_W-3:0], sq_s_q[k][VEC_W-1-2*k -: 2]};
      trial  = REM_W'({sq_root_q[k], 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_ctl_q[k+1]  <= '0;
        sq_root_q[k+1] <= '0;
      end else if (en_i) begin
        sq_ctl_q[k+1]  <= sq_ctl_q[k];
        sq_root_q[k+1] <= {sq_root_q[k][ROOT_W-2:0], ge};
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          sq_s_q[k+1]   <= '0;
          sq_rem_q[k+1] <= '0;
        end else if (en_i) begin
          sq_s_q[k+1]   <= sq_s_q[k];
          sq_rem_q[k+1] <= ge ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  // divide stages: q = (mag * 2^17 + len) / (2 * len), one quotient bit each
  nrm_ctl_t                       dv_ctl_q [0:NSH_W];
  logic [AXES-1:0][NSH_W-1:0]     dv_quo_q [0:NSH_W];
  logic [DEN_W-1:0]               dv_den_q [0:NSH_W-1];
  logic [AXES-1:0][NUM_W-1:0]     dv_num_q [0:NSH_W-1];
  logic [AXES-1:0][DREM_W-1:0]    dv_rem_q [0:NSH_W-1];
  logic [AXES-1:0][NUM_W-1:0]     num_d;
  logic [ROOT_W-1:0]              len;

  always_comb begin
    len = sq_root_q[ROOT_W];
    for (int i = 0; i < AXES; i++) begin
      num_d[i] = NUM_W'({sq_ctl_q[ROOT_W].mag[i], NSH_W'(0)}) + NUM_W'(len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_ctl_q[0] <= '0;
      dv_quo_q[0] <= '0;
      dv_den_q[0] <= '0;
      dv_num_q[0] <= '0;
      dv_rem_q[0] <= '0;
    end else if (en_i) begin
      dv_ctl_q[0] <= sq_ctl_q[ROOT_W];
      dv_quo_q[0] <= '0;
      dv_den_q[0] <= {len, 1'b0};
      dv_num_q[0] <= num_d;
      for (int i = 0; i < AXES; i++) begin
        dv_rem_q[0][i] <= DREM_W'(num_d[i][NUM_W-1:NSH_W]);
      end
    end
  end

  for (genvar j = 0; j < NSH_W; j++) begin : g_div
    logic [AXES-1:0][DREM_W-1:0] rs;
    logic [AXES-1:0]             ge;

    always_comb begin
      for (int i = 0; i < AXES; i++) begin
        rs[i] = {dv_rem_q[j][i][DREM_W-2:0], dv_num_q[j][i][NSH_W-1-j]};
        ge[i] = (rs[i] >= DREM_W'(dv_den_q[j]));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_ctl_q[j+1] <= '0;
        dv_quo_q[j+1] <= '0;
      end else if (en_i) begin
        dv_ctl_q[j+1] <= dv_ctl_q[j];
        for (int i = 0; i < AXES; i++) begin
          dv_quo_q[j+1][i] <= {dv_quo_q[j][i][NSH_W-2:0], ge[i]};
        end
      end
    end

    if (j < NSH_W - 1) begin : g_carry
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_den_q[j+1] <= '0;
          dv_num_q[j+1] <= '0;
          dv_rem_q[j+1] <= '0;
        end else if (en_i) begin
          dv_den_q[j+1] <= dv_den_q[j];
          dv_num_q[j+1] <= dv_num_q[j];
          for (int i = 0; i < AXES; i++) begin
            dv_rem_q[j+1][i] <= ge[i] ? (rs[i] - DREM_W'(dv_den_q[j])) : rs[i];
          end
        end
      end
    end
  end

  // final stage: apply sign, force zero-length vectors to zero
  unit3_t   unit_d;
  nrm_ctl_t last;

  always_comb begin
    last = dv_ctl_q[NSH_W];
    for (int i = 0; i < AXES; i++) begin
      if (last.zero)        unit_d[i] = '0;
      else if (last.neg[i]) unit_d[i] = UNIT_W'(0) - UNIT_W'(dv_quo_q[NSH_W][i]);
      else                  unit_d[i] = UNIT_W'(dv_quo_q[NSH_W][i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o  <= 1'b0;
      unit_o <= '0;
      side_o <= '0;
    end else if (en_i) begin
      vld_o  <= last.vld;
      unit_o <= unit_d;
      side_o <= last.side;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cvmb_core.sv
// Back end pipeline: normalize forward, cross, normalize up, cross, round, translations.
// Depends on cvmb_pkg and cvmb_norm. Every stage advances on en_i.
`default_nettype none

module cvmb_core
  import cvmb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      vld_i,
  input  in_item_t  item_i,
  output logic      vld_o,
  output res_item_t item_o
);

  // forward normalization
  wide3_t n1_vec;
  side_t  n1_side_in, n1_side;
  logic   n1_vld;
  unit3_t n1_fn;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      n1_vec[i] = {{(VEC_W-WORD_W){item_i.fwd[i][WORD_W-1]}}, item_i.fwd[i]};
    end
    n1_side_in.a   = item_i.right;
    n1_side_in.pos = item_i.pos;
  end

  cvmb_norm u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (vld_i),
    .vec_i  (n1_vec),
    .side_i (n1_side_in),
    .vld_o  (n1_vld),
    .unit_o (n1_fn),
    .side_o (n1_side)
  );

  // X1: products of forward x right
  logic                   x1_vld_q;
  unit3_t                 x1_fn_q;
  vec3_t                  x1_pos_q;
  logic [5:0][XP_W-1:0]   x1_p_q, x1_p_d;
  logic signed [XP_W-1:0] xp;

  always_comb begin
    xp = $signed(n1_fn[1]) * $signed(n1_side.a[2]); x1_p_d[0] = xp;
    xp = $signed(n1_fn[2]) * $signed(n1_side.a[1]); x1_p_d[1] = xp;
    xp = $signed(n1_fn[2]) * $signed(n1_side.a[0]); x1_p_d[2] = xp;
    xp = $signed(n1_fn[0]) * $signed(n1_side.a[2]); x1_p_d[3] = xp;
    xp = $signed(n1_fn[0]) * $signed(n1_side.a[1]); x1_p_d[4] = xp;
    xp = $signed(n1_fn[1]) * $signed(n1_side.a[0]); x1_p_d[5] = xp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q <= 1'b0;
      x1_fn_q  <= '0;
      x1_pos_q <= '0;
      x1_p_q   <= '0;
    end else if (en_i) begin
      x1_vld_q <= n1_vld;
      x1_fn_q  <= n1_fn;
      x1_pos_q <= n1_side.pos;
      x1_p_q   <= x1_p_d;
    end
  end

  // X2: cross product differences, exact Q32.32
  logic                    x2_vld_q;
  vec3_t                   x2_fn_q, x2_fn_d;
  vec3_t                   x2_pos_q;
  wide3_t                  x2_c_q, x2_c_d;
  logic signed [VEC_W-1:0] xa, xb;
  logic signed [WORD_W-1:0] xf;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      xa        = VEC_W'($signed(x1_p_q[2*i]));
      xb        = VEC_W'($signed(x1_p_q[2*i+1]));
      x2_c_d[i] = xa - xb;
      xf        = WORD_W'($signed(x1_fn_q[i]));
      x2_fn_d[i] = xf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x2_vld_q <= 1'b0;
      x2_fn_q  <= '0;
      x2_pos_q <= '0;
      x2_c_q   <= '0;
    end else if (en_i) begin
      x2_vld_q <= x1_vld_q;
      x2_fn_q  <= x2_fn_d;
      x2_pos_q <= x1_pos_q;
      x2_c_q   <= x2_c_d;
    end
  end

  // up normalization
  side_t  n2_side_in, n2_side;
  logic   n2_vld;
  unit3_t n2_up;

  always_comb begin
    n2_side_in.a   = x2_fn_q;
    n2_side_in.pos = x2_pos_q;
  end

  cvmb_norm u_norm_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (x2_vld_q),
    .vec_i  (x2_c_q),
    .side_i (n2_side_in),
    .vld_o  (n2_vld),
    .unit_o (n2_up),
    .side_o (n2_side)
  );

  // Y1: products of up x forward
  logic                   y1_vld_q;
  unit3_t                 y1_up_q, y1_fn_q, y1_fn_d;
  vec3_t                  y1_pos_q;
  logic [5:0][YP_W-1:0]   y1_p_q, y1_p_d;
  logic signed [YP_W-1:0] yp;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      y1_fn_d[i] = n2_side.a[i][UNIT_W-1:0];
    end
    yp = $signed(n2_up[1]) * $signed(y1_fn_d[2]); y1_p_d[0] = yp;
    yp = $signed(n2_up[2]) * $signed(y1_fn_d[1]); y1_p_d[1] = yp;
    yp = $signed(n2_up[2]) * $signed(y1_fn_d[0]); y1_p_d[2] = yp;
    yp = $signed(n2_up[0]) * $signed(y1_fn_d[2]); y1_p_d[3] = yp;
    yp = $signed(n2_up[0]) * $signed(y1_fn_d[1]); y1_p_d[4] = yp;
    yp = $signed(n2_up[1]) * $signed(y1_fn_d[0]); y1_p_d[5] = yp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_vld_q <= 1'b0;
      y1_up_q  <= '0;
      y1_fn_q  <= '0;
      y1_pos_q <= '0;
      y1_p_q   <= '0;
    end else if (en_i) begin
      y1_vld_q <= n2_vld;
      y1_up_q  <= n2_up;
      y1_fn_q  <= y1_fn_d;
      y1_pos_q <= n2_side.pos;
      y1_p_q   <= y1_p_d;
    end
  end

  // Y2: recomputed right, exact Q5.32
  logic                      y2_vld_q;
  unit3_t                    y2_up_q, y2_fn_q;
  vec3_t                     y2_pos_q;
  logic [AXES-1:0][RW_W-1:0] y2_rw_q, y2_rw_d;
  logic signed [RW_W-1:0]    ya, yb;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      ya         = RW_W'($signed(y1_p_q[2*i]));
      yb         = RW_W'($signed(y1_p_q[2*i+1]));
      y2_rw_d[i] = ya - yb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y2_vld_q <= 1'b0;
      y2_up_q  <= '0;
      y2_fn_q  <= '0;
      y2_pos_q <= '0;
      y2_rw_q  <= '0;
    end else if (en_i) begin
      y2_vld_q <= y1_vld_q;
      y2_up_q  <= y1_up_q;
      y2_fn_q  <= y1_fn_q;
      y2_pos_q <= y1_pos_q;
      y2_rw_q  <= y2_rw_d;
    end
  end

  // Y3: round right to Q4.16, half toward plus infinity
  logic                      y3_vld_q;
  unit3_t                    y3_up_q, y3_fn_q;
  vec3_t                     y3_pos_q;
  logic [AXES-1:0][RN_W-1:0] y3_rn_q, y3_rn_d;
  logic signed [RW_W:0]      yr;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      yr         = (RW_W+1)'($signed(y2_rw_q[i]));
      yr         = yr + (RW_W+1)'(1 << (FRAC_W - 1));
      y3_rn_d[i] = yr[RN_W+FRAC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y3_vld_q <= 1'b0;
      y3_up_q  <= '0;
      y3_fn_q  <= '0;
      y3_pos_q <= '0;
      y3_rn_q  <= '0;
    end else if (en_i) begin
      y3_vld_q <= y2_vld_q;
      y3_up_q  <= y2_up_q;
      y3_fn_q  <= y2_fn_q;
      y3_pos_q <= y2_pos_q;
      y3_rn_q  <= y3_rn_d;
    end
  end

  // D1: position times each axis, one row per translation
  logic                                  d1_vld_q;
  vec3_t                                 d1_rn_q, d1_up_q, d1_fn_q, d1_rn_d, d1_up_d, d1_fn_d;
  logic [AXES-1:0][AXES-1:0][DP_W-1:0]   d1_p_q, d1_p_d;
  logic signed [DP_W-1:0]                dp;
  logic signed [WORD_W-1:0]              ext;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      ext = WORD_W'($signed(y3_rn_q[i])); d1_rn_d[i] = ext;
      ext = WORD_W'($signed(y3_up_q[i])); d1_up_d[i] = ext;
      ext = WORD_W'($signed(y3_fn_q[i])); d1_fn_d[i] = ext;
      dp = $signed(y3_pos_q[i]) * $signed(y3_rn_q[i]); d1_p_d[0][i] = dp;
      dp = $signed(y3_pos_q[i]) * $signed(y3_up_q[i]); d1_p_d[1][i] = dp;
      dp = $signed(y3_pos_q[i]) * $signed(y3_fn_q[i]); d1_p_d[2][i] = dp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
      d1_rn_q  <= '0;
      d1_up_q  <= '0;
      d1_fn_q  <= '0;
      d1_p_q   <= '0;
    end else if (en_i) begin
      d1_vld_q <= y3_vld_q;
      d1_rn_q  <= d1_rn_d;
      d1_up_q  <= d1_up_d;
      d1_fn_q  <= d1_fn_d;
      d1_p_q   <= d1_p_d;
    end
  end

  // D2: dot products
  logic                      d2_vld_q;
  vec3_t                     d2_rn_q, d2_up_q, d2_fn_q;
  logic [AXES-1:0][DP_W-1:0] d2_dot_q, d2_dot_d;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      d2_dot_d[a] = d1_p_q[a][0] + d1_p_q[a][1] + d1_p_q[a][2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_vld_q <= 1'b0;
      d2_rn_q  <= '0;
      d2_up_q  <= '0;
      d2_fn_q  <= '0;
      d2_dot_q <= '0;
    end else if (en_i) begin
      d2_vld_q <= d1_vld_q;
      d2_rn_q  <= d1_rn_q;
      d2_up_q  <= d1_up_q;
      d2_fn_q  <= d1_fn_q;
      d2_dot_q <= d2_dot_d;
    end
  end

  // D3: negate, round and saturate translations
  vec3_t                trans_d;
  logic signed [DP_W:0] tv, ts;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ts = (DP_W+1)'($signed(d2_dot_q[a]));
      tv = (DP_W+1)'(1 << (FRAC_W - 1)) - ts;
      ts = tv >>> FRAC_W;
      if ((&ts[DP_W:WORD_W-1]) || !(|ts[DP_W:WORD_W-1])) begin
        trans_d[a] = ts[WORD_W-1:0];
      end else if (ts[DP_W]) begin
        trans_d[a] = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
        trans_d[a] = {1'b0, {(WORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o  <= 1'b0;
      item_o <= '0;
    end else if (en_i) begin
      vld_o        <= d2_vld_q;
      item_o.right <= d2_rn_q;
      item_o.up    <= d2_up_q;
      item_o.fwd   <= d2_fn_q;
      item_o.trans <= trans_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cvmb_out_queue.sv
// Result queue of the camera view matrix builder: holds finished items for the pop side.
// Depends on cvmb_pkg.
`default_nettype none

module cvmb_out_queue
  import cvmb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output res_item_t item_o
);

  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  res_item_t        mem_q [FIFO_DEPTH];
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

// File: rtl/camera_view_matrix_build.sv
// Camera view matrix builder, top level. Instantiates cvmb_front, cvmb_core and
// cvmb_out_queue; depends on cvmb_pkg.
//
// Input channel: a camera's right, forward and position vectors (Q16.16) are transferred
// at a clock edge with push high and full low. Result channel: while empty is low the
// oldest result (orthonormal right, up, forward and the three saturated translations)
// is on the output ports; pop high at an edge transfers it.
// From the push transfer to empty going low for that result, an item passes the input
// queue, two normalizers, each with 32 square root stages and 17 divide stages, and
// the cross, round and translation stages.
// Throughput: one item per cycle, sustained while the result side keeps popping.
// A four-entry queue on each side decouples the pipeline from both neighbors.
// When the result queue is full and a finished item reaches the last stage, the whole
// pipeline holds; the input queue then fills and raises full. No item is dropped.
// Reset (rst_ni low, asynchronous) empties both queues and clears every stage valid.
`default_nettype none

module camera_view_matrix_build
  import cvmb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] right_x_i,
  input  logic [31:0] right_y_i,
  input  logic [31:0] right_z_i,
  input  logic [31:0] forward_x_i,
  input  logic [31:0] forward_y_i,
  input  logic [31:0] forward_z_i,
  input  logic [31:0] position_x_i,
  input  logic [31:0] position_y_i,
  input  logic [31:0] position_z_i,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] out_right_x_o,
  output logic [31:0] out_right_y_o,
  output logic [31:0] out_right_z_o,
  output logic [31:0] out_up_x_o,
  output logic [31:0] out_up_y_o,
  output logic [31:0] out_up_z_o,
  output logic [31:0] out_forward_x_o,
  output logic [31:0] out_forward_y_o,
  output logic [31:0] out_forward_z_o,
  output logic [31:0] trans_right_o,
  output logic [31:0] trans_up_o,
  output logic [31:0] trans_forward_o
);

  in_item_t  in_item, head_item;
  res_item_t core_item, res_item;
  logic      head_vld, core_vld, oq_full, advance;

  assign in_item.right = {right_z_i, right_y_i, right_x_i};
  assign in_item.fwd   = {forward_z_i, forward_y_i, forward_x_i};
  assign in_item.pos   = {position_z_i, position_y_i, position_x_i};

  // hold the pipeline only when a finished item has nowhere to go
  assign advance = !(core_vld && oq_full);

  cvmb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item),
    .full_o (full),
    .pop_i  (advance),
    .vld_o  (head_vld),
    .item_o (head_item)
  );

  cvmb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .vld_i  (head_vld),
    .item_i (head_item),
    .vld_o  (core_vld),
    .item_o (core_item)
  );

  cvmb_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_vld),
    .item_i  (core_item),
    .full_o  (oq_full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (res_item)
  );

  assign out_right_x_o   = res_item.right[0];
  assign out_right_y_o   = res_item.right[1];
  assign out_right_z_o   = res_item.right[2];
  assign out_up_x_o      = res_item.up[0];
  assign out_up_y_o      = res_item.up[1];
  assign out_up_z_o      = res_item.up[2];
  assign out_forward_x_o = res_item.fwd[0];
  assign out_forward_y_o = res_item.fwd[1];
  assign out_forward_z_o = res_item.fwd[2];
  assign trans_right_o   = res_item.trans[0];
  assign trans_up_o      = res_item.trans[1];
  assign trans_forward_o = res_item.trans[2];

endmodule

`default_nettype wire

// File: sim/camera_view_matrix_build_tb.sv
// Testbench for camera_view_matrix_build: random and directed camera bases are pushed,
// results are popped and checked against a bit-exact fixed-point predictor.
// Depends only on the block's RTL (cvmb_pkg and camera_view_matrix_build).
`timescale 1ns / 100ps

module camera_view_matrix_build_tb;

  typedef struct {
    logic [31:0] r[3];
    logic [31:0] f[3];
    logic [31:0] p[3];
  } camera_t;

  typedef struct {
    logic [31:0] v[12];
  } view_t;

  class view_scoreboard;
    view_t expected_views[$];
    int    errors;

    function longint unsigned sqrt_floor(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= root + bitv) begin
          x -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function void unit_vec(input longint v[3], output longint o[3]);
      longint unsigned mag[3], m, s, len, q;
      bit neg[3];
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? -v[i] : v[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        for (int i = 0; i < 3; i++) o[i] = 0;
        return;
      end
      while (m >= (64'd1 << 31)) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 30)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      len = sqrt_floor(s);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 64'd131072 + len) / (len * 2);
        o[i] = neg[i] ? -longint'(q) : longint'(q);
      end
    endfunction

    function void cross_prod(input longint a[3], input longint b[3], output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function logic [31:0] neg_dot_sat(longint p[3], longint axis[3]);
      longint t;
      t = round_q16(-(p[0] * axis[0] + p[1] * axis[1] + p[2] * axis[2]));
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[31:0];
    endfunction

    function void note_camera(camera_t c);
      longint r[3], f[3], p[3], fn[3], cr[3], up[3], rw[3], rn[3];
      view_t e;
      for (int i = 0; i < 3; i++) begin
        r[i] = longint'($signed(c.r[i]));
        f[i] = longint'($signed(c.f[i]));
        p[i] = longint'($signed(c.p[i]));
      end
      unit_vec(f, fn);
      cross_prod(fn, r, cr);
      unit_vec(cr, up);
      cross_prod(up, fn, rw);
      for (int i = 0; i < 3; i++) begin
        rn[i] = round_q16(rw[i]);
        e.v[i] = rn[i][31:0];
        e.v[3+i] = up[i][31:0];
        e.v[6+i] = fn[i][31:0];
      end
      e.v[9] = neg_dot_sat(p, rn);
      e.v[10] = neg_dot_sat(p, up);
      e.v[11] = neg_dot_sat(p, fn);
      expected_views.push_back(e);
    endfunction

    function void check_view(view_t a);
      string names[12] = '{"right_x", "right_y", "right_z", "up_x", "up_y", "up_z",
                           "forward_x", "forward_y", "forward_z",
                           "trans_right", "trans_up", "trans_forward"};
      view_t e;
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
        return;
      end
      e = expected_views.pop_front();
      for (int i = 0; i < 12; i++)
        if (a.v[i] !== e.v[i]) begin
          $display("%0t: %s expected %h actual %h", $time, names[i], e.v[i], a.v[i]);
          errors++;
        end
    endfunction
  endclass

  logic        clk_i, rst_ni, push, full, pop, empty;
  logic [31:0] cam_in[9];
  logic [31:0] view_out[12];

  view_scoreboard sb = new();
  int snd_idle, rcv_idle;
  bit hold_req;

  camera_view_matrix_build dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .right_x_i(cam_in[0]), .right_y_i(cam_in[1]), .right_z_i(cam_in[2]),
    .forward_x_i(cam_in[3]), .forward_y_i(cam_in[4]), .forward_z_i(cam_in[5]),
    .position_x_i(cam_in[6]), .position_y_i(cam_in[7]), .position_z_i(cam_in[8]),
    .pop(pop), .empty(empty),
    .out_right_x_o(view_out[0]), .out_right_y_o(view_out[1]), .out_right_z_o(view_out[2]),
    .out_up_x_o(view_out[3]), .out_up_y_o(view_out[4]), .out_up_z_o(view_out[5]),
    .out_forward_x_o(view_out[6]), .out_forward_y_o(view_out[7]),
    .out_forward_z_o(view_out[8]),
    .trans_right_o(view_out[9]), .trans_up_o(view_out[10]), .trans_forward_o(view_out[11])
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("camera_view_matrix_build_tb: FAIL");
    $finish;
  end

  // Idle cycles before the item, then hold push until the transfer.
  task automatic send_camera(camera_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cam_in[i] = c.r[i];
      cam_in[3+i] = c.f[i];
      cam_in[6+i] = c.p[i];
    end
    forever begin
      @(posedge clk_i);
      if (!full) break;
      @(negedge clk_i);
    end
    sb.note_camera(c);
  endtask

  task automatic send_vecs(logic [31:0] r0, r1, r2, f0, f1, f2, p0, p1, p2);
    camera_t c;
    c.r = '{r0, r1, r2};
    c.f = '{f0, f1, f2};
    c.p = '{p0, p1, p2};
    send_camera(c);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(262144)) - 131072);
      2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(16777216)) - 8388608);
    endcase
  endfunction

  function automatic camera_t rand_camera();
    camera_t c;
    int k;
    for (int i = 0; i < 3; i++) begin
      c.r[i] = rand_word();
      c.f[i] = rand_word();
      c.p[i] = rand_word();
    end
    case ($urandom_range(15))
      0: c.f = '{0, 0, 0};
      1: begin
        k = $urandom_range(4) - 2;
        for (int i = 0; i < 3; i++) c.r[i] = c.f[i] * k;
      end
      2: c.r = '{0, 0, 0};
      default: ;
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    while (sb.expected_views.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: pop at random, with a long hold-off on request.
  initial begin
    view_t a;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end
      pop = $urandom_range(99) >= rcv_idle;
      @(posedge clk_i);
      if (pop && !empty) begin
        for (int i = 0; i < 12; i++) a.v[i] = view_out[i];
        sb.check_view(a);
      end
    end
  end

  localparam logic [31:0] ONE = 32'h00010000;
  localparam logic [31:0] MAXW = 32'h7fffffff;
  localparam logic [31:0] MINW = 32'h80000000;

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    hold_req = 1'b0;
    snd_idle = 0;
    rcv_idle = 0;
    foreach (cam_in[i]) cam_in[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // identity basis, zero forward, zero and parallel right, extremes, huge position
    send_vecs(ONE, 0, 0, 0, 0, ONE, 0, 0, 0);
    send_vecs(ONE, 0, 0, 0, 0, ONE, ONE, 2 * ONE, -3 * ONE);
    send_vecs(ONE, ONE, 0, 0, 0, 0, ONE, ONE, ONE);
    send_vecs(0, 0, 0, ONE, ONE, 0, 5 * ONE, 0, 0);
    send_vecs(2 * ONE, 0, 0, -ONE, 0, 0, ONE, ONE, ONE);
    send_vecs(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW);
    send_vecs(MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW);
    send_vecs(MAXW, MINW, 0, MINW, MAXW, 1, MAXW, MINW, MAXW);
    send_vecs(0, MAXW, 0, MINW, 0, 0, MINW, MINW, MINW);
    send_vecs(0, ONE, 0, 1, 0, 0, MAXW, MAXW, MAXW);
    send_vecs(1, 0, 0, 0, 1, 0, MINW, MAXW, 0);
    send_vecs(0, 0, 1, 0, 0, -1, 7, 8, 9);
    send_vecs(32'hffffffff, 1, 32'hffffffff, 1, 32'hffffffff, 1, MAXW, 0, MINW);
    send_vecs(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
    send_vecs(ONE, 0, 0, 3, 4, 0, 32'h12345678, 32'hedcba987, 32'h0f0f0f0f);
    send_vecs(32'haaaaaaaa, 32'h55555555, 32'hcccccccc, 32'h33333333, 32'hf0f0f0f0,
              32'h0f0f0f0f, 32'haaaaaaaa, 32'h55555555, 32'hffffffff);

    snd_idle = 24;
    rcv_idle = 45;
    repeat (530) send_camera(rand_camera());
    // hold off the receiver while the sender keeps offering more than the block holds
    hold_req = 1'b1;
    snd_idle = 0;
    repeat (200) send_camera(rand_camera());
    @(negedge clk_i);
    push = 1'b0;
    wait_drained();

    snd_idle = 45;
    rcv_idle = 24;
    repeat (500) send_camera(rand_camera());
    snd_idle = 0;
    rcv_idle = 0;
    repeat (370) send_camera(rand_camera());
    @(negedge clk_i);
    push = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_views.size() == 0)
      $display("camera_view_matrix_build_tb: PASS");
    else
      $display("camera_view_matrix_build_tb: FAIL");
    $finish;
  end

endmodule
